/* rtl/mf2d_pkg.sv */
// Package for the 2-D median filter: request/response payload types,
// register indexes and the sequencer state type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mf2d_pkg;
   localparam int PIXEL_W = 16;
   localparam int POS_W   = 10;
   localparam int CSR_W   = 11;

   localparam logic CSR_RADIUS = 1'b0;
   localparam logic CSR_SIDE   = 1'b1;

   typedef struct packed {
      logic signed [PIXEL_W-1:0] pixel_value;
      logic                      frame_start;
   } req_type;

   typedef struct packed {
      logic signed [PIXEL_W-1:0] median_pix;
      logic [POS_W-1:0]          out_row;
      logic [POS_W-1:0]          out_col;
      logic                      end_of_image;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_SHIFT,
      ST_LAST,
      ST_LOAD_A,
      ST_CMP,
      ST_CHECK,
      ST_EMIT
   } state_type;
endpackage
`default_nettype wire

/* rtl/mf2d_linebuf.sv */
// Line store for the median filter: single write port, one registered
// read port. Uses mf2d_pkg for the pixel width.
`timescale 1ns / 1ps
`default_nettype none
module mf2d_linebuf #(
   parameter int DEPTH  = 6144,
   parameter int ADDR_W = 13
) (
   input  wire logic                               clock,
   input  wire logic                               wr_en,
   input  wire logic [ADDR_W-1:0]                  wr_addr,
   input  wire logic signed [mf2d_pkg::PIXEL_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0]                  rd_addr,
   output logic signed [mf2d_pkg::PIXEL_W-1:0]      rd_data
);
   import mf2d_pkg::*;

   logic signed [PIXEL_W-1:0] mem [DEPTH];
   logic signed [PIXEL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

/* rtl/median_filter_2d_top.sv */
// 2-D median filter top level: position tracking, window grid, rank-count
// sequencer and output register. Uses mf2d_pkg and mf2d_linebuf.
//
// Usage:
//   Pixels arrive on req_* in row-major order; frame_start marks the first
//   pixel of an image. csr_* sets the window radius (index 0) and image side
//   (index 1); write them only while the block is idle.
//   Each request first pulls s-1 earlier rows from the line store, one row
//   at a time through the single store port (read, then shift), then shifts
//   in the new window column. Where the window lies inside the image, the
//   median is found by rank counting with one shared comparator: each
//   candidate (n = s*s of them at most) is loaded, compared with all n
//   window pixels and checked, until one holds the middle rank.
//   req_stall is high while a request is in work. The response sits in an
//   output register; a stalled response holds, and the next request may
//   already be taken meanwhile. A further result waits until the register
//   is free. Reset clears position, registers and handshake state; the
//   line store and window contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module median_filter_2d_top #(
   parameter int MAX_WINDOW     = 7,
   parameter int MAX_IMAGE_SIDE = 1024
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire mf2d_pkg::req_type          req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output mf2d_pkg::rsp_type               rsp_data,
   input  wire logic                       csr_we,
   input  wire logic                       csr_index,
   input  wire logic [mf2d_pkg::CSR_W-1:0] csr_wdata
);
   import mf2d_pkg::*;

   localparam int LS     = (MAX_WINDOW > 1) ? MAX_WINDOW - 1 : 1;
   localparam int PW     = $clog2(MAX_IMAGE_SIDE);
   localparam int SLW    = (LS > 1) ? $clog2(LS) : 1;
   localparam int DEPTH  = LS * MAX_IMAGE_SIDE;
   localparam int AW     = $clog2(DEPTH);
   localparam int SW     = $clog2(MAX_WINDOW + 1);
   localparam int GW     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CW     = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
   localparam int SIDEW  = $clog2(MAX_IMAGE_SIDE + 1);
   localparam int RAD_MAX = (MAX_WINDOW - 1) / 2;

   state_type                 state_ff, state_in;
   logic [1:0]                rad_ff;
   logic [CSR_W-1:0]          side_cfg_ff;
   logic signed [PIXEL_W-1:0] pix_ff, pix_in;
   logic [PW-1:0]             row_ff, row_in, col_ff, col_in;
   logic [SLW-1:0]            slot_ff, slot_in;
   logic [SW-1:0]             s_ff, s_in;
   logic [SIDEW-1:0]          side_ff, side_in;
   logic [GW-1:0]             i_ff, i_in;
   logic                      rvalid_ff, rvalid_in;
   logic [GW-1:0]             ar_ff, ar_in, ac_ff, ac_in, br_ff, br_in, bc_ff, bc_in;
   logic signed [PIXEL_W-1:0] va_ff, va_in;
   logic [CW-1:0]             less_ff, less_in, eq_ff, eq_in;
   logic signed [PIXEL_W-1:0] med_ff, med_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;
   logic signed [PIXEL_W-1:0] grid_ff [MAX_WINDOW][MAX_WINDOW];
   logic signed [PIXEL_W-1:0] grid_in [MAX_WINDOW][MAX_WINDOW];

   logic                      mem_we;
   logic [AW-1:0]             mem_waddr, mem_raddr;
   logic signed [PIXEL_W-1:0] mem_rdata;

   logic signed [PIXEL_W-1:0] grid_rd;
   logic [GW-1:0]             rd_r, rd_c;
   logic                      produce;

   mf2d_linebuf #(
      .DEPTH  (DEPTH),
      .ADDR_W (AW)
   ) u_linebuf (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (pix_ff),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // the one shared read port into the window and the one comparator
   assign rd_r    = (state_ff == ST_LOAD_A) ? ar_ff : br_ff;
   assign rd_c    = (state_ff == ST_LOAD_A) ? ac_ff : bc_ff;
   assign grid_rd = grid_ff[rd_r][rd_c];

   assign produce = (int'(side_ff) >= int'(s_ff)) && (int'(row_ff) >= int'(s_ff) - 1)
                    && (int'(col_ff) >= int'(s_ff) - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rad_ff       <= 2'd1;
         side_cfg_ff  <= CSR_W'(64);
         row_ff       <= '0;
         col_ff       <= '0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_RADIUS: rad_ff <= csr_wdata[1:0];
               CSR_SIDE:   side_cfg_ff <= csr_wdata;
               default:    ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      pix_ff    <= pix_in;
      s_ff      <= s_in;
      side_ff   <= side_in;
      i_ff      <= i_in;
      rvalid_ff <= rvalid_in;
      ar_ff     <= ar_in;
      ac_ff     <= ac_in;
      br_ff     <= br_in;
      bc_ff     <= bc_in;
      va_ff     <= va_in;
      less_ff   <= less_in;
      eq_ff     <= eq_in;
      med_ff    <= med_in;
      rsp_ff    <= rsp_in;
      grid_ff   <= grid_in;
   end

   always_comb begin
      int side_t, rad_t, r_t, c_t, sl_t, back_t, src_t, mid_t, s_t;
      logic                      do_shift, adv;
      logic [GW-1:0]             shift_row;
      logic signed [PIXEL_W-1:0] new_pix;

      state_in     = state_ff;
      pix_in       = pix_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      slot_in      = slot_ff;
      s_in         = s_ff;
      side_in      = side_ff;
      i_in         = i_ff;
      rvalid_in    = rvalid_ff;
      ar_in        = ar_ff;
      ac_in        = ac_ff;
      br_in        = br_ff;
      bc_in        = bc_ff;
      va_in        = va_ff;
      less_in      = less_ff;
      eq_in        = eq_ff;
      med_in       = med_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      grid_in      = grid_ff;
      mem_we       = 1'b0;
      mem_waddr    = AW'(int'(slot_ff) * MAX_IMAGE_SIDE + int'(col_ff));
      mem_raddr    = mem_waddr;
      do_shift     = 1'b0;
      adv          = 1'b0;
      shift_row    = i_ff;
      new_pix      = pix_ff;
      s_t          = int'(s_ff);
      mid_t        = (s_t * s_t) / 2;
      back_t       = s_t - 1 - int'(i_ff);

      side_t = int'(side_cfg_ff);
      if (side_t == 0) side_t = 1;
      if (side_t > MAX_IMAGE_SIDE) side_t = MAX_IMAGE_SIDE;
      rad_t = (int'(rad_ff) > RAD_MAX) ? RAD_MAX : int'(rad_ff);
      r_t = int'(row_ff);
      c_t = int'(col_ff);
      sl_t = int'(slot_ff);
      src_t = 0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.frame_start) begin
                  r_t = 0;
                  c_t = 0;
                  sl_t = 0;
               end
               if (c_t >= side_t) begin
                  c_t = 0;
                  r_t = r_t + 1;
                  sl_t = (sl_t == LS - 1) ? 0 : sl_t + 1;
               end
               if (r_t >= side_t) begin
                  r_t = 0;
                  sl_t = 0;
               end
               row_in  = PW'(r_t);
               col_in  = PW'(c_t);
               slot_in = SLW'(sl_t);
               pix_in  = req_data.pixel_value;
               side_in = SIDEW'(side_t);
               s_in    = SW'(2 * rad_t + 1);
               i_in    = '0;
               state_in = (rad_t == 0) ? ST_LAST : ST_READ;
            end
         end
         ST_READ: begin
            // row i of the window comes from 'back' rows above
            rvalid_in = (int'(row_ff) >= back_t);
            src_t = (int'(slot_ff) >= back_t) ? int'(slot_ff) - back_t
                                              : int'(slot_ff) + LS - back_t;
            mem_raddr = AW'(src_t * MAX_IMAGE_SIDE + int'(col_ff));
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            do_shift = 1'b1;
            new_pix  = rvalid_ff ? mem_rdata : '0;
            if (int'(i_ff) == s_t - 2) begin
               state_in = ST_LAST;
            end else begin
               i_in = i_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_LAST: begin
            do_shift  = 1'b1;
            shift_row = GW'(s_t - 1);
            new_pix   = pix_ff;
            mem_we    = 1'b1;
            ar_in     = '0;
            ac_in     = '0;
            if (produce) begin
               state_in = ST_LOAD_A;
            end else begin
               adv = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_LOAD_A: begin
            va_in   = grid_rd;
            less_in = '0;
            eq_in   = '0;
            br_in   = '0;
            bc_in   = '0;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (grid_rd < va_ff) begin
               less_in = less_ff + 1'b1;
            end else if (grid_rd == va_ff) begin
               eq_in = eq_ff + 1'b1;
            end
            if (int'(bc_ff) == s_t - 1) begin
               bc_in = '0;
               if (int'(br_ff) == s_t - 1) begin
                  state_in = ST_CHECK;
               end else begin
                  br_in = br_ff + 1'b1;
               end
            end else begin
               bc_in = bc_ff + 1'b1;
            end
         end
         ST_CHECK: begin
            if (int'(less_ff) <= mid_t && mid_t < int'(less_ff) + int'(eq_ff)) begin
               med_in = va_ff;
               state_in = ST_EMIT;
            end else if (int'(ac_ff) == s_t - 1) begin
               ac_in = '0;
               if (int'(ar_ff) == s_t - 1) begin
                  med_in = '0;
                  state_in = ST_EMIT;
               end else begin
                  ar_in = ar_ff + 1'b1;
                  state_in = ST_LOAD_A;
               end
            end else begin
               ac_in = ac_ff + 1'b1;
               state_in = ST_LOAD_A;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in        = 1'b1;
               rsp_in.median_pix   = med_ff;
               rsp_in.out_row      = POS_W'(int'(row_ff) - (s_t - 1));
               rsp_in.out_col      = POS_W'(int'(col_ff) - (s_t - 1));
               rsp_in.end_of_image = (int'(row_ff) == int'(side_ff) - 1)
                                     && (int'(col_ff) == int'(side_ff) - 1);
               adv = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // step to the next pixel position
      if (adv) begin
         c_t = int'(col_ff) + 1;
         r_t = int'(row_ff);
         sl_t = int'(slot_ff);
         if (c_t >= int'(side_ff)) begin
            c_t = 0;
            r_t = r_t + 1;
            sl_t = (sl_t == LS - 1) ? 0 : sl_t + 1;
            if (r_t >= int'(side_ff)) begin
               r_t = 0;
               sl_t = 0;
            end
         end
         row_in  = PW'(r_t);
         col_in  = PW'(c_t);
         slot_in = SLW'(sl_t);
      end

      // shift one window row left and insert the new column at s-1
      if (do_shift) begin
         for (int ii = 0; ii < MAX_WINDOW; ii++) begin
            if (ii == int'(shift_row)) begin
               for (int jj = 0; jj < MAX_WINDOW; jj++) begin
                  if (jj + 1 < s_t) begin
                     grid_in[ii][jj] = grid_ff[ii][(jj + 1) % MAX_WINDOW];
                  end else if (jj + 1 == s_t) begin
                     grid_in[ii][jj] = new_pix;
                  end
               end
            end
         end
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule
`default_nettype wire

/* tb/tb_median_filter_2d_top.sv */
// Testbench for median_filter_2d_top: directed and random pixel streams under
// several window and image settings, checked by a predicting scoreboard.
// Depends on mf2d_pkg and the RTL of the median filter.
`timescale 1ns / 1ps

class median_scoreboard;
   int unsigned radius_reg;
   int unsigned side_reg;
   int line_rows[6*1024];
   int grid[49];
   int unsigned col_pos;
   int unsigned row_pos;
   mf2d_pkg::rsp_type medians_due[$];
   int errors;
   int results_seen;

   function new();
      radius_reg = 1;
      side_reg = 64;
      col_pos = 0;
      row_pos = 0;
      errors = 0;
      results_seen = 0;
      foreach (line_rows[k]) line_rows[k] = 0;
      foreach (grid[k]) grid[k] = 0;
   endfunction

   function void set_reg(logic idx, int unsigned val);
      if (idx == mf2d_pkg::CSR_RADIUS) radius_reg = val & 3;
      else side_reg = val & 'h7ff;
   endfunction

   function int window_median(int unsigned s);
      int vals[49];
      int unsigned n;
      int t;
      int k;
      n = s * s;
      for (int a = 0; a < n; a++) vals[a] = grid[(a / s) * 7 + (a % s)];
      for (int a = 1; a < n; a++) begin
         t = vals[a];
         k = a - 1;
         while (k >= 0 && vals[k] > t) begin
            vals[k+1] = vals[k];
            k--;
         end
         vals[k+1] = t;
      end
      return vals[n/2];
   endfunction

   // accepted request: advance position and window, queue a median if due
   function void note_pixel(mf2d_pkg::req_type q);
      int px;
      int unsigned side, rad, s, r, c, back;
      mf2d_pkg::rsp_type e;
      px = q.pixel_value;
      side = side_reg;
      rad = radius_reg;
      if (side == 0) side = 1;
      if (side > 1024) side = 1024;
      if (rad > 3) rad = 3;
      s = 2 * rad + 1;
      if (q.frame_start) begin
         col_pos = 0;
         row_pos = 0;
      end
      if (col_pos >= side) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= side) row_pos = 0;
      r = row_pos;
      c = col_pos;
      for (int unsigned i = 0; i < s; i++) begin
         for (int unsigned j = 0; j + 1 < s; j++) grid[i*7+j] = grid[i*7+j+1];
         if (i + 1 == s) grid[i*7+s-1] = px;
         else begin
            back = s - 1 - i;
            grid[i*7+s-1] = (r >= back) ? line_rows[((r - back) % 6) * 1024 + c] : 0;
         end
      end
      if (side >= s && r >= s - 1 && c >= s - 1) begin
         e.median_pix = mf2d_pkg::PIXEL_W'(window_median(s));
         e.out_row = mf2d_pkg::POS_W'(r - (s - 1));
         e.out_col = mf2d_pkg::POS_W'(c - (s - 1));
         e.end_of_image = (r == side - 1 && c == side - 1);
         medians_due.push_back(e);
      end
      line_rows[(r % 6) * 1024 + c] = px;
      c++;
      if (c >= side) begin
         c = 0;
         r++;
         if (r >= side) r = 0;
      end
      col_pos = c;
      row_pos = r;
   endfunction

   function void check_median(mf2d_pkg::rsp_type got);
      mf2d_pkg::rsp_type e;
      results_seen++;
      if (medians_due.size() == 0) begin
         $error("unexpected response %h", got);
         errors++;
         return;
      end
      e = medians_due.pop_front();
      if (got.median_pix !== e.median_pix) begin
         $error("median_pix exp %0d got %0d", e.median_pix, got.median_pix);
         errors++;
      end
      if (got.out_row !== e.out_row) begin
         $error("out_row exp %0d got %0d", e.out_row, got.out_row);
         errors++;
      end
      if (got.out_col !== e.out_col) begin
         $error("out_col exp %0d got %0d", e.out_col, got.out_col);
         errors++;
      end
      if (got.end_of_image !== e.end_of_image) begin
         $error("end_of_image exp %0d got %0d", e.end_of_image, got.end_of_image);
         errors++;
      end
   endfunction
endclass

module tb_median_filter_2d_top;
   import mf2d_pkg::*;

   localparam int CYCLE_LIMIT = 20000000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic csr_we;
   logic csr_index;
   logic [CSR_W-1:0] csr_wdata;

   median_scoreboard sb;
   int send_idle_pct;
   int recv_stall_pct;
   int cycles = 0;
   int pixels_sent;

   median_filter_2d_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAILURE");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_stall <= (recv_stall_pct > 0) && ($urandom_range(0, 99) < recv_stall_pct);

   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall) sb.check_median(rsp_data);

   task automatic send_pixel(logic signed [15:0] px, logic fs);
      req_type q;
      while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      q.pixel_value = px;
      q.frame_start = fs;
      req_valid <= 1'b1;
      req_data <= q;
      do @(posedge clock); while (req_stall);
      sb.note_pixel(q);
      pixels_sent++;
      @(negedge clock);
   endtask

   // block must be idle before a register write
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.medians_due.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_reg(logic idx, int unsigned val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_W'(val);
      @(negedge clock);
      csr_we <= 1'b0;
      sb.set_reg(idx, val);
      @(negedge clock);
   endtask

   task automatic set_window(int unsigned rad, int unsigned side);
      drain();
      write_reg(CSR_RADIUS, rad);
      write_reg(CSR_SIDE, side);
   endtask

   function automatic logic signed [15:0] rand_pixel();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 6) return 16'($urandom_range(0, 65535));
      if (roll < 8) return 16'($signed($urandom_range(0, 4)) - 2);  // ties
      case ($urandom_range(0, 3))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'sh0000;
         default: return -16'sd1;
      endcase
   endfunction

   initial begin
      logic signed [15:0] corner[9];
      int ph_rad[8];
      int ph_side[8];
      sb = new();
      pixels_sent = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = CSR_RADIUS;
      csr_wdata = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // 3x3 on a 3x3 image with extreme values; single result
      corner = '{16'sh7fff, 16'sh8000, 16'sh0000, -16'sd1, 16'sh7fff,
                 16'sh8000, 16'sd1, 16'sh7ffe, 16'sh8001};
      set_window(1, 3);
      foreach (corner[k]) send_pixel(corner[k], k == 0);
      // side register zero acts as 1: every pixel is its own image
      set_window(0, 0);
      send_pixel(16'sh8000, 1'b1);
      send_pixel(16'sh7fff, 1'b0);
      send_pixel(16'sh5555, 1'b0);
      // image smaller than the 7x7 window: nothing comes out
      set_window(3, 2);
      for (int k = 0; k < 4; k++) send_pixel(rand_pixel(), k == 0);
      // oversized side saturates; only a few row-0 pixels
      set_window(0, 2047);
      for (int k = 0; k < 4; k++) send_pixel(16'shaaaa ^ 16'(k), k == 0);

      ph_rad = '{1, 0, 2, 3, 1, 3, 2, 0};
      ph_side = '{8, 16, 6, 7, 12, 9, 5, 1023};
      for (int p = 0; p < 8; p++) begin
         set_window(ph_rad[p], ph_side[p]);
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
            default: begin send_idle_pct = 17; recv_stall_pct = 17; end
         endcase
         for (int k = 0; k < 178; k++)
            send_pixel(rand_pixel(), k == 0 || $urandom_range(0, 99) == 0);
         send_idle_pct = 0;
         recv_stall_pct = 0;
      end

      drain();
      $display("covered %0d requests, %0d medians, radius 0..3, sides 1..1024",
               pixels_sent, sb.results_seen);
      if (sb.errors == 0 && sb.medians_due.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

/* files.f */
rtl/mf2d_pkg.sv
rtl/mf2d_linebuf.sv
rtl/median_filter_2d_top.sv
tb/tb_median_filter_2d_top.sv
